/* sv/kvte_pkg.sv */
// ----------------------------------------------------------------------------
// kvte_pkg - key/value table engine package
// Table sizes, operation and status codes, request and response item types.
// ----------------------------------------------------------------------------
package kvte_pkg;

	// table geometry
	localparam int DEPTH      = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// operation codes
	localparam logic [2:0] OP_SET      = 3'd0;
	localparam logic [2:0] OP_LOOKUP   = 3'd1;
	localparam logic [2:0] OP_REM_KEY  = 3'd2;
	localparam logic [2:0] OP_REM_VAL  = 3'd3;
	localparam logic [2:0] OP_KEYS_VAL = 3'd4;
	localparam logic [2:0] OP_SWAP     = 3'd5;
	localparam logic [2:0] OP_CLEAR    = 3'd6;
	localparam logic [2:0] OP_UNUSED   = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [2:0]            operation;
		logic [KEY_BITS-1:0]   key;
		logic [KEY_BITS-1:0]   second_key;
		logic [VALUE_BITS-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] value_out;
		logic [KEY_BITS-1:0]   key_out;
		logic [CNT_W-1:0]      entry_total;
		logic [1:0]            status;
		logic                  last;
	} rsp_item_t;

endpackage

/* sv/key_value_table_engine_top.sv */
// Sequence: a result is registered from S_DONE once the scan has walked every entry after its
// request transfer (clear and unused codes skip the walk); keys-with-value lists its keys from
// S_LIST after a counting pass.
// Throughput: one request at a time; the single compare unit walks one entry per clock, and the
// next transfer is taken only once the sequencer is back in idle, later still while a result is
// held by rsp_stall (which also holds the listing pass at each matching entry).
// Reset (arst_n low) empties the table and drops any pending result.
// ----------------------------------------------------------------------------
// key_value_table_engine_top - linear search key/value table
// Insertion-ordered table searched one entry per cycle by a small sequencer.
// Removals compact the table in the same pass as the search.
// ----------------------------------------------------------------------------
module key_value_table_engine_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  kvte_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output kvte_pkg::rsp_item_t  rsp
);
	import kvte_pkg::*;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      w_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      e_q;
	logic                  hit_a_q;
	logic                  hit_b_q;
	logic [IDX_W-1:0]      pa_q;
	logic [IDX_W-1:0]      pb_q;
	logic [VALUE_BITS-1:0] va_q;
	logic [VALUE_BITS-1:0] vb_q;
	req_item_t             op_q;

	// table storage
	logic [KEY_BITS-1:0]   key_store   [DEPTH];
	logic [VALUE_BITS-1:0] value_store [DEPTH];

	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  scan_end;
	logic                  key_hit;
	logic                  key2_hit;
	logic                  val_hit;
	logic                  out_free;
	logic                  accept;

	logic                  kw_en;
	logic                  vw_en;
	logic                  vw2_en;
	logic [IDX_W-1:0]      w_idx;
	logic [IDX_W-1:0]      w2_idx;
	logic [KEY_BITS-1:0]   kw_data;
	logic [VALUE_BITS-1:0] vw_data;
	logic [VALUE_BITS-1:0] vw2_data;

	logic                  rsp_load;
	rsp_item_t             rsp_nxt;

	// shared compare unit on the entry under the scan pointer
	assign rd_key   = key_store[idx_q[IDX_W-1:0]];
	assign rd_val   = value_store[idx_q[IDX_W-1:0]];
	assign scan_end = (idx_q == count_q);
	assign key_hit  = (rd_key == op_q.key);
	assign key2_hit = (rd_key == op_q.second_key);
	assign val_hit  = (rd_val == op_q.value);

	assign out_free  = !rsp_valid || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	// table write decode: compaction during scan, update at the end
	always_comb begin
		kw_en    = 1'b0;
		vw_en    = 1'b0;
		vw2_en   = 1'b0;
		w_idx    = w_q[IDX_W-1:0];
		w2_idx   = pb_q;
		kw_data  = rd_key;
		vw_data  = rd_val;
		vw2_data = va_q;
		case (state_q)
			S_SCAN: begin
				if (!scan_end && ((op_q.operation == OP_REM_KEY && !key_hit) ||
				                  (op_q.operation == OP_REM_VAL && !val_hit))) begin
					kw_en = 1'b1;
					vw_en = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free && op_q.operation == OP_SET) begin
					if (hit_a_q) begin
						vw_en   = 1'b1;
						w_idx   = pa_q;
						vw_data = op_q.value;
					end else if (count_q < CNT_W'(DEPTH)) begin
						kw_en   = 1'b1;
						vw_en   = 1'b1;
						w_idx   = count_q[IDX_W-1:0];
						kw_data = op_q.key;
						vw_data = op_q.value;
					end
				end else if (out_free && op_q.operation == OP_SWAP &&
				             hit_a_q && hit_b_q) begin
					vw_en   = 1'b1;
					w_idx   = pa_q;
					vw_data = vb_q;
					vw2_en  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (kw_en) begin
			key_store[w_idx] <= kw_data;
		end
		if (vw_en) begin
			value_store[w_idx] <= vw_data;
		end
		if (vw2_en) begin
			value_store[w2_idx] <= vw2_data;
		end
	end

	// result build
	always_comb begin
		rsp_load    = 1'b0;
		rsp_nxt     = '0;
		rsp_nxt.entry_total = count_q;
		rsp_nxt.last        = 1'b1;
		case (state_q)
			S_LIST: begin
				rsp_load            = val_hit && out_free;
				rsp_nxt.found       = 1'b1;
				rsp_nxt.key_out     = rd_key;
				rsp_nxt.entry_total = n_q;
				rsp_nxt.last        = (e_q + CNT_W'(1) == n_q);
			end
			S_DONE: begin
				rsp_load = out_free;
				case (op_q.operation)
					OP_SET: begin
						if (hit_a_q) begin
							rsp_nxt.found = 1'b1;
						end else if (count_q < CNT_W'(DEPTH)) begin
							rsp_nxt.entry_total = count_q + CNT_W'(1);
						end else begin
							rsp_nxt.status = ST_FULL;
						end
					end
					OP_LOOKUP: begin
						rsp_nxt.found     = hit_a_q;
						rsp_nxt.value_out = hit_a_q ? va_q : '0;
						rsp_nxt.status    = hit_a_q ? ST_OK : ST_NOT_FOUND;
					end
					OP_REM_KEY, OP_REM_VAL: begin
						rsp_nxt.found  = hit_a_q;
						rsp_nxt.status = hit_a_q ? ST_OK : ST_NOT_FOUND;
						if (hit_a_q) begin
							rsp_nxt.entry_total = w_q;
						end
					end
					OP_KEYS_VAL: begin
						// only reached when nothing matched
						rsp_nxt.entry_total = '0;
						rsp_nxt.status      = ST_NOT_FOUND;
					end
					OP_SWAP: begin
						rsp_nxt.found  = hit_a_q && hit_b_q;
						rsp_nxt.status = (hit_a_q && hit_b_q) ? ST_OK : ST_NOT_FOUND;
					end
					OP_CLEAR: begin
						rsp_nxt.entry_total = '0;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			w_q       <= '0;
			n_q       <= '0;
			e_q       <= '0;
			hit_a_q   <= 1'b0;
			hit_b_q   <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						w_q     <= '0;
						n_q     <= '0;
						e_q     <= '0;
						hit_a_q <= 1'b0;
						hit_b_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end || op_q.operation == OP_CLEAR ||
					    op_q.operation == OP_UNUSED) begin
						idx_q <= '0;
						if (op_q.operation == OP_KEYS_VAL && n_q != '0) begin
							state_q <= S_LIST;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						idx_q <= idx_q + CNT_W'(1);
						case (op_q.operation)
							OP_SET, OP_LOOKUP: begin
								if (key_hit) begin
									hit_a_q <= 1'b1;
								end
							end
							OP_REM_KEY: begin
								if (key_hit) begin
									hit_a_q <= 1'b1;
								end else begin
									w_q <= w_q + CNT_W'(1);
								end
							end
							OP_REM_VAL: begin
								if (val_hit) begin
									hit_a_q <= 1'b1;
								end else begin
									w_q <= w_q + CNT_W'(1);
								end
							end
							OP_KEYS_VAL: begin
								if (val_hit) begin
									n_q <= n_q + CNT_W'(1);
								end
							end
							OP_SWAP: begin
								if (key_hit) begin
									hit_a_q <= 1'b1;
								end
								if (key2_hit) begin
									hit_b_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LIST: begin
					// one matching key per transfer, stepping past a match only when it is taken
					if (!val_hit) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (out_free) begin
						idx_q <= idx_q + CNT_W'(1);
						e_q   <= e_q + CNT_W'(1);
						if (e_q + CNT_W'(1) == n_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (op_q.operation)
							OP_SET: begin
								if (!hit_a_q && count_q < CNT_W'(DEPTH)) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_REM_KEY, OP_REM_VAL: begin
								if (hit_a_q) begin
									count_q <= w_q;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, match positions and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req;
		end
		if (state_q == S_SCAN && !scan_end && key_hit) begin
			pa_q <= idx_q[IDX_W-1:0];
			va_q <= rd_val;
		end
		if (state_q == S_SCAN && !scan_end && key2_hit) begin
			pb_q <= idx_q[IDX_W-1:0];
			vb_q <= rd_val;
		end
		if (rsp_load) begin
			rsp <= rsp_nxt;
		end
	end

endmodule
